>>> rtl/xtkbd_pkg.sv
package xtkbd_pkg;

	// key queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_KEY   = 2'd3;

	// port offsets
	localparam logic [1:0] OFS_PORT_A = 2'd0;
	localparam logic [1:0] OFS_PORT_B = 2'd1;
	localparam logic [1:0] OFS_PORT_C = 2'd2;
	localparam logic [1:0] OFS_CTRL   = 2'd3;

	// codes and words
	localparam logic [7:0] CODE_HANDSHAKE = 8'hAA;
	localparam logic [7:0] CODE_OVERRUN   = 8'hFF;
	localparam logic [7:0] OPEN_BUS       = 8'hFF;
	localparam logic [7:0] CTRL_MODE_A    = 8'h89;
	localparam logic [7:0] CTRL_MODE_B    = 8'h99;

	// port B bits
	localparam int PB_CLEAR_BIT = 7;
	localparam int PB_CLK_BIT   = 6;

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_HANDSHAKE_DELAY = 1'd0;
	localparam logic [CFG_IW-1:0] REG_SWITCH_BYTE     = 1'd1;
	localparam logic [15:0] RST_HANDSHAKE_DELAY = 16'd300;
	localparam logic [7:0]  RST_SWITCH_BYTE     = 8'd45;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  reg_offset;
		logic [7:0]  write_data;
		logic [7:0]  key_code;
		logic [15:0] tick_count;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_raise;
		logic       irq_lower;
		logic       access_error;
		logic       key_dropped;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic       empty;
		logic       full;
		logic [7:0] head_data;
	} fifo_stat_t;

endpackage

>>> rtl/xtkbd_fifo.sv
module xtkbd_fifo import xtkbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_ctl_t  ctl,
	input  logic [7:0] push_data,
	output fifo_stat_t stat
);

	logic [7:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_CW-1:0] fill_q;
	logic [FIFO_AW-1:0] head_nxt;
	logic [FIFO_AW-1:0] tail_nxt;

	assign head_nxt = (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign stat.empty     = (fill_q == '0);
	assign stat.full      = (fill_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.head_data = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_nxt;
				fill_q <= fill_q + 1'b1;
			end else if (ctl.pop) begin
				head_q <= head_nxt;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full) else $error("push into full key queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.empty) else $error("pop from empty key queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> fill_q != '0) else $error("fill count wrapped on push");

endmodule

>>> rtl/xtkbd_core.sv
module xtkbd_core import xtkbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  item_t       item,
	input  logic [15:0] handshake_delay,
	input  logic [7:0]  switch_byte,
	output result_t     res
);

	logic [7:0]  ctrl_q, ctrl_d;
	logic        latch_valid_q, latch_valid_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] countdown_q, countdown_d;
	logic [15:0] countdown_left;
	logic        hs_fire;
	logic        kbd_enabled;
	fifo_ctl_t   fctl_raw;
	fifo_ctl_t   fctl;
	fifo_stat_t  fstat;

	assign countdown_left = (item.tick_count > countdown_q) ? '0
		: countdown_q - item.tick_count;
	assign hs_fire     = (countdown_q != '0) && (countdown_left == '0);
	assign kbd_enabled = !ctrl_q[PB_CLEAR_BIT] && ctrl_q[PB_CLK_BIT];

	always_comb begin
		res           = '0;
		fctl_raw      = '0;
		ctrl_d        = ctrl_q;
		latch_valid_d = latch_valid_q;
		code_d        = code_q;
		countdown_d   = countdown_q;
		case (item.kind)
			KIND_TICK: begin
				if (countdown_q != '0) begin
					countdown_d = countdown_left;
				end
				if (hs_fire) begin
					res.irq_raise = 1'b1;
					if (latch_valid_q) begin
						code_d = CODE_OVERRUN;
					end else begin
						latch_valid_d = 1'b1;
						code_d        = CODE_HANDSHAKE;
					end
				end else if (!latch_valid_q && kbd_enabled && !fstat.empty) begin
					res.irq_raise = 1'b1;
					latch_valid_d = 1'b1;
					code_d        = fstat.head_data;
					fctl_raw.pop  = 1'b1;
				end
			end
			KIND_READ: begin
				case (item.reg_offset)
					OFS_PORT_A: begin
						if (!latch_valid_q) begin
							res.read_data = (code_q == CODE_HANDSHAKE) ? '0 : code_q;
						end else begin
							latch_valid_d = 1'b0;
							res.read_data = code_q;
						end
					end
					OFS_PORT_B: res.read_data = ctrl_q;
					OFS_PORT_C: res.read_data = switch_byte;
					default: begin
						res.read_data    = OPEN_BUS;
						res.access_error = 1'b1;
					end
				endcase
			end
			KIND_WRITE: begin
				case (item.reg_offset)
					OFS_PORT_B: begin
						if (item.write_data[PB_CLEAR_BIT]) begin
							latch_valid_d = 1'b0;
							res.irq_lower = 1'b1;
						end
						// rising edge of the clock enable starts the reset handshake
						if (item.write_data[PB_CLK_BIT] && !ctrl_q[PB_CLK_BIT]) begin
							countdown_d = handshake_delay;
						end
						ctrl_d = item.write_data;
					end
					OFS_CTRL: begin
						res.access_error = !(item.write_data inside {CTRL_MODE_A, CTRL_MODE_B});
					end
					OFS_PORT_C: res.access_error = 1'b1;
					default: ;
				endcase
			end
			KIND_KEY: begin
				if (fstat.full) begin
					res.key_dropped = 1'b1;
				end else begin
					fctl_raw.push = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign fctl = step ? fctl_raw : '0;

	xtkbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fctl),
		.push_data (item.key_code),
		.stat      (fstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q        <= '0;
			latch_valid_q <= 1'b0;
			code_q        <= '0;
			countdown_q   <= '0;
		end else if (step) begin
			ctrl_q        <= ctrl_d;
			latch_valid_q <= latch_valid_d;
			code_q        <= code_d;
			countdown_q   <= countdown_d;
		end
	end

	a_pop_fills_latch: assert property (@(posedge clk) disable iff (!arst_n)
		fctl.pop |=> latch_valid_q && code_q == $past(fstat.head_data))
		else $error("dequeued key not latched");

	a_clear_drops_latch: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.kind == KIND_WRITE && item.reg_offset == OFS_PORT_B
		&& item.write_data[PB_CLEAR_BIT] |=> !latch_valid_q)
		else $error("port B clear left the latch full");

	a_countdown_load: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.kind == KIND_WRITE && item.reg_offset == OFS_PORT_B
		&& item.write_data[PB_CLK_BIT] && !ctrl_q[PB_CLK_BIT]
		|=> countdown_q == $past(handshake_delay))
		else $error("handshake countdown not loaded on clock enable edge");

	a_raise_lower_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(res.irq_raise && res.irq_lower))
		else $error("raise and lower in one result");

endmodule

>>> rtl/xt_keyboard_port_interface_top.sv
// Keyboard interface seen through the port registers of an 8255-style PPI.
// Input channel (in_valid/in_ready): one beat is a tick, a bus read, a bus
// write or a key code to queue, chosen by kind; reg_offset picks port A, B,
// C or the control port. Output channel (out_valid/out_ready): exactly one
// result beat per input beat, in order, carrying read data and the IRQ,
// error and drop flags.
// Path: an accepted beat goes through the input register, then the result
// register, before it is presented on the output.
// Throughput: one beat per cycle unless out_ready stalls; state updates for
// a beat happen between the two registers, so the next beat sees them.
// Configuration (cfg_we/cfg_index/cfg_data) writes the handshake delay and
// the switch byte; write only while no beat is in flight.
// Reset: delay 300, switch byte 45, port B zero, latch empty, countdown
// stopped, key queue empty (16 entries).
// Receiver stall: the result register holds; one more beat may wait in the
// input register, then in_ready falls until out_ready returns.
module xt_keyboard_port_interface_top import xtkbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [1:0]        reg_offset,
	input  logic [7:0]        write_data,
	input  logic [7:0]        key_code,
	input  logic [15:0]       tick_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_data,
	output logic              irq_raise,
	output logic              irq_lower,
	output logic              access_error,
	output logic              key_dropped
);

	logic [15:0] handshake_delay_q;
	logic [7:0]  switch_byte_q;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res_s2;
	logic        valid_s2;
	result_t     res;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handshake_delay_q <= RST_HANDSHAKE_DELAY;
			switch_byte_q     <= RST_SWITCH_BYTE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HANDSHAKE_DELAY: handshake_delay_q <= cfg_data[15:0];
				REG_SWITCH_BYTE:     switch_byte_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{kind: kind, reg_offset: reg_offset, write_data: write_data,
				key_code: key_code, tick_count: tick_count};
		end
	end

	xtkbd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (adv_s1),
		.item            (item_s1),
		.handshake_delay (handshake_delay_q),
		.switch_byte     (switch_byte_q),
		.res             (res)
	);

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign read_data    = res_s2.read_data;
	assign irq_raise    = res_s2.irq_raise;
	assign irq_lower    = res_s2.irq_lower;
	assign access_error = res_s2.access_error;
	assign key_dropped  = res_s2.key_dropped;

endmodule
